// ----- sv/png_unf_pkg.sv -----
// ----------------------------------------------------------------------------
// png_unf_pkg
// Shared widths, filter codes, register indexes and the predictor operand
// bundle for the PNG scanline unfilter.
// ----------------------------------------------------------------------------
package png_unf_pkg;

  // Data byte and line buffer geometry
  localparam int BYTE_W          = 8;
  localparam int MAX_ROW_BYTES   = 4096;
  localparam int ROW_ADDR_W      = $clog2(MAX_ROW_BYTES);
  localparam int MAX_PIXEL_BYTES = 8;

  // Configuration write port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BYTES = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS  = CFG_IDX_W'(2);

  // Filter codes of one scanline
  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_e;

  // Operands for reconstructing one byte
  typedef struct packed {
    filter_e             filter;
    logic [BYTE_W-1:0]   raw;    // filtered byte from the stream
    logic [BYTE_W-1:0]   left;   // a: one pixel to the left
    logic [BYTE_W-1:0]   up;     // b: row above
    logic [BYTE_W-1:0]   upleft; // c: row above, one pixel to the left
  } pred_in_t;

endpackage

// ----- sv/png_unf_line_buf.sv -----
// ----------------------------------------------------------------------------
// png_unf_line_buf
// Previous-row line buffer: one write and one registered read per cycle.
// A read of the address written in the same cycle returns the new byte.
// ----------------------------------------------------------------------------
module png_unf_line_buf (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic [png_unf_pkg::ROW_ADDR_W-1:0]          rd_addr_i,
  input  logic                                       wr_en_i,
  input  logic [png_unf_pkg::ROW_ADDR_W-1:0]          wr_addr_i,
  input  logic [png_unf_pkg::BYTE_W-1:0]              wr_data_i,
  output logic [png_unf_pkg::BYTE_W-1:0]              rd_data_o
);
  import png_unf_pkg::*;

  logic [BYTE_W-1:0] line_mem [MAX_ROW_BYTES];
  logic [BYTE_W-1:0] rd_q;
  logic [BYTE_W-1:0] byp_data_q;
  logic              byp_q;

  // Storage array, read before write
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      line_mem[wr_addr_i] <= wr_data_i;
    end
    rd_q       <= line_mem[rd_addr_i];
    byp_data_q <= wr_data_i;
  end

  // Same-address write forwarding flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : rd_q;

endmodule

// ----- sv/png_unf_predictor.sv -----
// ----------------------------------------------------------------------------
// png_unf_predictor
// Combinational byte reconstruction: none, sub, up, average and Paeth
// predictors, then the mod-256 add of the filtered byte.
// ----------------------------------------------------------------------------
module png_unf_predictor (
  input  png_unf_pkg::pred_in_t              pred_i,
  output logic [png_unf_pkg::BYTE_W-1:0]     pixel_o
);
  import png_unf_pkg::*;

  logic [BYTE_W+1:0] sum_ab;
  logic [BYTE_W+1:0] sum_cc;
  logic [BYTE_W+1:0] dist_a;
  logic [BYTE_W+1:0] dist_b;
  logic [BYTE_W+1:0] dist_c;
  logic [BYTE_W-1:0] avg;
  logic [BYTE_W-1:0] paeth;
  logic [BYTE_W-1:0] pred;

  // Paeth distances, kept unsigned by ordering each difference
  always_comb begin
    sum_ab = {2'b00, pred_i.left} + {2'b00, pred_i.up};
    sum_cc = {1'b0, pred_i.upleft, 1'b0};
    dist_a = (pred_i.up >= pred_i.upleft) ? {2'b00, pred_i.up - pred_i.upleft}
                                          : {2'b00, pred_i.upleft - pred_i.up};
    dist_b = (pred_i.left >= pred_i.upleft) ? {2'b00, pred_i.left - pred_i.upleft}
                                            : {2'b00, pred_i.upleft - pred_i.left};
    dist_c = (sum_ab >= sum_cc) ? (sum_ab - sum_cc) : (sum_cc - sum_ab);
    avg    = sum_ab[BYTE_W:1];
  end

  // Nearest neighbor, ties go to left then up
  always_comb begin
    priority if (dist_a <= dist_b && dist_a <= dist_c) begin
      paeth = pred_i.left;
    end else if (dist_b <= dist_c) begin
      paeth = pred_i.up;
    end else begin
      paeth = pred_i.upleft;
    end
  end

  // Predictor select
  always_comb begin
    unique case (pred_i.filter)
      FILT_NONE:  pred = '0;
      FILT_SUB:   pred = pred_i.left;
      FILT_UP:    pred = pred_i.up;
      FILT_AVG:   pred = avg;
      FILT_PAETH: pred = paeth;
      default:    pred = '0;
    endcase
  end

  assign pixel_o = pred_i.raw + pred;

endmodule

// ----- sv/png_scanline_unfilter_core.sv -----
// ----------------------------------------------------------------------------
// png_scanline_unfilter_core
// PNG scanline unfilter: rebuilds raw scanline bytes from the inflated
// stream, one byte per transfer, with a previous-row line buffer.
//
//   Channel   Direction  Handshake             Payload
//   -------   ---------  --------------------  ------------------------------
//   in        sink       in_valid / in_stall   encoded_byte
//   out       source     out_valid / out_stall pixel_byte, last_in_row,
//                                              last_in_image, bad_filter
//   cfg       sink       cfg_we                cfg_index, cfg_wdata
//
// One byte per clock while the output is not stalled: each byte is rebuilt
// in the cycle it is taken and lands in the result register on that edge.
// The filter code byte opening each scanline yields no result but still
// takes an input transfer. The column address, left-neighbor slot and edge
// flags of the next byte are registered ahead of it, as is the line buffer
// read. in_stall follows out_stall only while the result register holds a
// byte. Reset is asynchronous; the line buffer contents are not cleared.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input stream
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [png_unf_pkg::BYTE_W-1:0]     encoded_byte_i,
  // Result stream
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [png_unf_pkg::BYTE_W-1:0]     pixel_byte_o,
  output logic                               last_in_row_o,
  output logic                               last_in_image_o,
  output logic                               bad_filter_o,
  // Configuration writes
  input  logic                               cfg_we_i,
  input  logic [png_unf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [png_unf_pkg::CFG_W-1:0]      cfg_wdata_i
);
  import png_unf_pkg::*;

  localparam int COL_W   = 13;
  localparam int PB_W    = 4;
  localparam int ROWS_W  = 16;
  localparam int SLOT_W  = $clog2(MAX_PIXEL_BYTES);
  localparam int NSLOT   = MAX_PIXEL_BYTES;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W  = ROW_ADDR_W + RECIP_SHIFT;
  localparam logic [COL_W-1:0] MaxRow = COL_W'(MAX_ROW_BYTES);
  localparam logic [PB_W-1:0]  MaxPix = PB_W'(NSLOT);
  // Reciprocals floor(2^16/k)+1, exact for any 12-bit column
  localparam logic [RECIP_SHIFT-1:0] Recip3 = RECIP_SHIFT'(21846);
  localparam logic [RECIP_SHIFT-1:0] Recip5 = RECIP_SHIFT'(13108);
  localparam logic [RECIP_SHIFT-1:0] Recip6 = RECIP_SHIFT'(10923);
  localparam logic [RECIP_SHIFT-1:0] Recip7 = RECIP_SHIFT'(9363);

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  function automatic logic [COL_W-1:0] eff_row_bytes(input logic [COL_W-1:0] v);
    logic [COL_W-1:0] r;
    r = v;
    if (v == '0) r = COL_W'(1);
    else if (v > MaxRow) r = MaxRow;
    return r;
  endfunction

  function automatic logic [PB_W-1:0] eff_pixel_bytes(input logic [PB_W-1:0] v);
    logic [PB_W-1:0] r;
    r = v;
    if (v == '0) r = PB_W'(1);
    else if (v > MaxPix) r = MaxPix;
    return r;
  endfunction

  // x mod k by reciprocal multiply, k a small constant
  function automatic logic [SLOT_W-1:0] mod_const(input logic [ROW_ADDR_W-1:0] x,
                                                 input logic [ROW_ADDR_W-1:0] k,
                                                 input logic [RECIP_SHIFT-1:0] m);
    logic [PROD_W-1:0]     prod;
    logic [ROW_ADDR_W-1:0] quo;
    logic [ROW_ADDR_W-1:0] rem;
    prod = PROD_W'(x) * PROD_W'(m);
    quo  = prod[RECIP_SHIFT +: ROW_ADDR_W];
    rem  = x - ROW_ADDR_W'(quo * k);
    return rem[SLOT_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] col_mod(input logic [ROW_ADDR_W-1:0] x,
                                               input logic [PB_W-1:0] pb);
    logic [SLOT_W-1:0] r;
    unique case (pb)
      PB_W'(2): r = {2'b00, x[0]};
      PB_W'(3): r = mod_const(x, ROW_ADDR_W'(3), Recip3);
      PB_W'(4): r = {1'b0, x[1:0]};
      PB_W'(5): r = mod_const(x, ROW_ADDR_W'(5), Recip5);
      PB_W'(6): r = mod_const(x, ROW_ADDR_W'(6), Recip6);
      PB_W'(7): r = mod_const(x, ROW_ADDR_W'(7), Recip7);
      PB_W'(8): r = x[SLOT_W-1:0];
      default:  r = '0;
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Declarations
  // --------------------------------------------------------------------------
  logic [COL_W-1:0]      row_bytes_q, row_bytes_d;
  logic [PB_W-1:0]       pixel_bytes_q, pixel_bytes_d;
  logic [ROWS_W-1:0]     image_rows_q, image_rows_d;

  logic                  awaiting_q, awaiting_d;
  filter_e               active_filter_q, active_filter_d;
  logic                  row_bad_q, row_bad_d;
  logic [COL_W-1:0]      column_position_q, column_position_d;
  logic [ROWS_W-1:0]     row_position_q, row_position_d;

  logic [ROW_ADDR_W-1:0] col_eff_q, col_eff_d;
  logic [SLOT_W-1:0]     slot_q, slot_d;
  logic                  has_left_q, has_left_d;
  logic                  last_col_q, last_col_d;

  logic [BYTE_W-1:0]     left_hist_q [NSLOT];
  logic [BYTE_W-1:0]     upleft_hist_q [NSLOT];

  logic                  out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]     pixel_byte_q;
  logic                  last_in_row_q;
  logic                  last_in_image_q;
  logic                  bad_filter_q;

  logic                  in_xfer;
  logic                  code_xfer;
  logic                  data_xfer;
  logic                  first_row;
  logic                  end_row;
  logic                  end_image;
  logic [COL_W-1:0]      rb_eff;
  logic [PB_W-1:0]       pb_eff;
  logic [ROWS_W-1:0]     rows_eff;
  logic [COL_W-1:0]      rb_eff_d;
  logic [PB_W-1:0]       pb_eff_d;
  logic [COL_W-1:0]      col_clamp_d;
  logic [BYTE_W-1:0]     line_rd;
  logic [BYTE_W-1:0]     pixel;
  pred_in_t              pred_in;

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign code_xfer  = in_xfer && awaiting_q;
  assign data_xfer  = in_xfer && !awaiting_q;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_comb begin
    row_bytes_d   = row_bytes_q;
    pixel_bytes_d = pixel_bytes_q;
    image_rows_d  = image_rows_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ROW_BYTES:   row_bytes_d   = cfg_wdata_i[COL_W-1:0];
        CFG_PIXEL_BYTES: pixel_bytes_d = cfg_wdata_i[PB_W-1:0];
        CFG_IMAGE_ROWS:  image_rows_d  = cfg_wdata_i[ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  assign rb_eff   = eff_row_bytes(row_bytes_q);
  assign pb_eff   = eff_pixel_bytes(pixel_bytes_q);
  assign rows_eff = (image_rows_q == '0) ? ROWS_W'(1) : image_rows_q;

  // --------------------------------------------------------------------------
  // Neighbors of the current byte
  // --------------------------------------------------------------------------
  assign first_row = (row_position_q == '0);

  always_comb begin
    pred_in.filter = active_filter_q;
    pred_in.raw    = encoded_byte_i;
    pred_in.left   = has_left_q ? left_hist_q[slot_q] : '0;
    pred_in.upleft = (has_left_q && !first_row) ? upleft_hist_q[slot_q] : '0;
    pred_in.up     = first_row ? '0 : line_rd;
  end

  png_unf_predictor u_predictor (
    .pred_i  (pred_in),
    .pixel_o (pixel)
  );

  assign end_row   = last_col_q;
  assign end_image = end_row &&
                     (({1'b0, row_position_q} + (ROWS_W + 1)'(1)) >= {1'b0, rows_eff});

  // --------------------------------------------------------------------------
  // Scanline sequencing
  // --------------------------------------------------------------------------
  always_comb begin
    awaiting_d        = awaiting_q;
    active_filter_d   = active_filter_q;
    row_bad_d         = row_bad_q;
    column_position_d = column_position_q;
    row_position_d    = row_position_q;
    if (code_xfer) begin
      row_bad_d         = (encoded_byte_i > BYTE_W'(FILT_PAETH));
      active_filter_d   = row_bad_d ? FILT_NONE : filter_e'(encoded_byte_i[2:0]);
      awaiting_d        = 1'b0;
      column_position_d = '0;
    end else if (data_xfer) begin
      if (end_row) begin
        column_position_d = '0;
        awaiting_d        = 1'b1;
        row_position_d    = end_image ? '0 : row_position_q + ROWS_W'(1);
      end else begin
        column_position_d = {1'b0, col_eff_q} + COL_W'(1);
      end
    end
  end

  // Column, slot and edge flags for the next byte, registered ahead of it
  always_comb begin
    rb_eff_d    = eff_row_bytes(row_bytes_d);
    pb_eff_d    = eff_pixel_bytes(pixel_bytes_d);
    col_clamp_d = (column_position_d >= rb_eff_d) ? rb_eff_d - COL_W'(1)
                                                  : column_position_d;
    col_eff_d   = col_clamp_d[ROW_ADDR_W-1:0];
    slot_d      = col_mod(col_eff_d, pb_eff_d);
    has_left_d  = (col_clamp_d >= COL_W'(pb_eff_d));
    last_col_d  = ((col_clamp_d + COL_W'(1)) >= rb_eff_d);
  end

  png_unf_line_buf u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (col_eff_d),
    .wr_en_i   (data_xfer),
    .wr_addr_i (col_eff_q),
    .wr_data_i (pixel),
    .rd_data_o (line_rd)
  );

  // Result register valid
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (data_xfer) out_valid_d = 1'b1;
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_bytes_q       <= COL_W'(1);
      pixel_bytes_q     <= PB_W'(1);
      image_rows_q      <= ROWS_W'(1);
      awaiting_q        <= 1'b1;
      active_filter_q   <= FILT_NONE;
      row_bad_q         <= 1'b0;
      column_position_q <= '0;
      row_position_q    <= '0;
      col_eff_q         <= '0;
      slot_q            <= '0;
      has_left_q        <= 1'b0;
      last_col_q        <= 1'b1;
      out_valid_q       <= 1'b0;
    end else begin
      row_bytes_q       <= row_bytes_d;
      pixel_bytes_q     <= pixel_bytes_d;
      image_rows_q      <= image_rows_d;
      awaiting_q        <= awaiting_d;
      active_filter_q   <= active_filter_d;
      row_bad_q         <= row_bad_d;
      column_position_q <= column_position_d;
      row_position_q    <= row_position_d;
      col_eff_q         <= col_eff_d;
      slot_q            <= slot_d;
      has_left_q        <= has_left_d;
      last_col_q        <= last_col_d;
      out_valid_q       <= out_valid_d;
    end
  end

  // Left and upper-left history, one byte per pixel slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSLOT; i++) begin
        left_hist_q[i]   <= '0;
        upleft_hist_q[i] <= '0;
      end
    end else if (data_xfer) begin
      left_hist_q[slot_q]   <= pixel;
      upleft_hist_q[slot_q] <= pred_in.up;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (data_xfer) begin
      pixel_byte_q    <= pixel;
      last_in_row_q   <= end_row;
      last_in_image_q <= end_image;
      bad_filter_q    <= row_bad_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_byte_o    = pixel_byte_q;
  assign last_in_row_o   = last_in_row_q;
  assign last_in_image_o = last_in_image_q;
  assign bad_filter_o    = bad_filter_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_image_end_is_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && last_in_image_q) |-> last_in_row_q)
    else $error("image end flagged without row end");

  a_row_end_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (data_xfer && end_row) |=> (awaiting_q && column_position_q == '0))
    else $error("row end did not return to filter code");

  a_slot_in_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, slot_q} < pb_eff)
    else $error("left slot outside pixel");

  a_col_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, col_eff_q} < rb_eff) &&
    (has_left_q == ({1'b0, col_eff_q} >= COL_W'(pb_eff))))
    else $error("column state inconsistent with configuration");

endmodule

// ----- dv/tb_png_scanline_unfilter_core.sv -----
// ----------------------------------------------------------------------------
// tb_png_scanline_unfilter_core
// Self-checking bench for the PNG scanline unfilter. A behavioral unfilter
// predicts every rebuilt byte and its row, image and bad-filter flags as each
// byte transfer is accepted. A monitor compares each output transfer, field
// by field, with the oldest prediction. Directed rows cover every filter
// type, first-row behavior, left-edge handling and bad filter codes. Further
// tests cover register extremes and registers changed mid-image. Random
// images then run with random gaps on the input and random output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_png_scanline_unfilter_core;
  import png_unf_pkg::*;

  localparam int          SETTLE_CYCLES   = 4;
  localparam int          DRAIN_LIMIT     = 2000;
  localparam int          CYCLE_LIMIT     = 3000000;
  localparam int          RANDOM_ITEMS    = 1500;
  localparam int          STREAM_IMAGES   = 6;
  localparam int          MAX_REPORTS     = 100;

  // Filter codes above Paeth are bad
  localparam logic [7:0] BAD_CODE_MIN = 8'd5;
  localparam logic [7:0] BAD_CODE_MAX = 8'd255;

  // One expected output transfer
  typedef struct packed {
    logic [7:0] pixel;
    logic       row_end;
    logic       image_end;
    logic       bad;
  } pixel_result_t;

  // Directed rows: three data bytes each, two bytes per pixel
  localparam logic [7:0] DIRECTED_BYTES [24] = '{
    8'(FILT_UP),    8'h00, 8'hFF, 8'h80,
    8'(FILT_PAETH), 8'hFF, 8'h01, 8'h7F,
    8'(FILT_AVG),   8'hFF, 8'hFF, 8'hFF,
    8'(FILT_SUB),   8'h80, 8'h80, 8'h01,
    8'(FILT_NONE),  8'h5A, 8'hA5, 8'h00,
    BAD_CODE_MAX,   8'h12, 8'h34, 8'h56
  };

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 in_valid       = 1'b0;
  logic [BYTE_W-1:0]    encoded_byte   = '0;
  logic                 out_stall      = 1'b0;
  logic                 cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index      = '0;
  logic [CFG_W-1:0]     cfg_wdata      = '0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  logic [BYTE_W-1:0]    pixel_byte_o;
  logic                 last_in_row_o;
  logic                 last_in_image_o;
  logic                 bad_filter_o;

  // Unfilter state mirrored by the bench
  logic [7:0]  line_mem    [MAX_ROW_BYTES]   = '{default: 8'h00};
  logic [7:0]  left_hist   [MAX_PIXEL_BYTES] = '{default: 8'h00};
  logic [7:0]  upleft_hist [MAX_PIXEL_BYTES] = '{default: 8'h00};
  int unsigned col_pos         = 0;
  int unsigned row_pos         = 0;
  filter_e     cur_filter      = FILT_NONE;
  bit          want_code       = 1'b1;
  bit          row_bad         = 1'b0;
  int unsigned cfg_row_bytes   = 1;
  int unsigned cfg_pixel_bytes = 1;
  int unsigned cfg_image_rows  = 1;

  pixel_result_t expected_pixels [$];
  int            mismatch_count = 0;
  int            items_sent     = 0;
  int            cycle_count    = 0;
  int            no_gap_left    = 0;
  bit            gaps_on        = 1'b1;
  bit            stalls_on      = 1'b1;

  png_scanline_unfilter_core u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .encoded_byte_i  (encoded_byte),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .pixel_byte_o    (pixel_byte_o),
    .last_in_row_o   (last_in_row_o),
    .last_in_image_o (last_in_image_o),
    .bad_filter_o    (bad_filter_o),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Paeth: pick whichever neighbor is closest to a + b - c
  function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c);
    int da, db, dc;
    da = int'(b) - int'(c);
    db = int'(a) - int'(c);
    dc = int'(a) + int'(b) - 2 * int'(c);
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) return a;
    if (db <= dc) return b;
    return c;
  endfunction

  // Effective register values after clamping
  function automatic int unsigned eff_row_bytes();
    if (cfg_row_bytes == 0) return 1;
    if (cfg_row_bytes > MAX_ROW_BYTES) return MAX_ROW_BYTES;
    return cfg_row_bytes;
  endfunction

  function automatic int unsigned eff_image_rows();
    return (cfg_image_rows == 0) ? 1 : cfg_image_rows;
  endfunction

  // Consume one stream byte; a data byte yields one rebuilt pixel byte
  function automatic void unfilter_byte(input logic [7:0] enc, output bit produced,
                                        output pixel_result_t res);
    int unsigned rb, pxb, col, slot;
    logic [7:0]  a, b, c, pred, val;
    bit          first_row, row_end, img_end;
    rb  = eff_row_bytes();
    pxb = (cfg_pixel_bytes == 0) ? 1 : cfg_pixel_bytes;
    if (pxb > MAX_PIXEL_BYTES) pxb = MAX_PIXEL_BYTES;
    produced = 1'b0;
    res      = '0;
    if (want_code) begin
      row_bad    = (enc > 8'(FILT_PAETH));
      cur_filter = row_bad ? FILT_NONE : filter_e'(enc[2:0]);
      want_code  = 1'b0;
      col_pos    = 0;
      return;
    end
    // a position past a shrunken row counts as its last byte
    col       = (col_pos >= rb) ? rb - 1 : col_pos;
    slot      = col % pxb;
    first_row = (row_pos == 0);
    a = (col >= pxb) ? left_hist[slot] : 8'h00;
    c = (col >= pxb && !first_row) ? upleft_hist[slot] : 8'h00;
    b = first_row ? 8'h00 : line_mem[col];
    case (cur_filter)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = 8'((int'(a) + int'(b)) >> 1);
      FILT_PAETH: pred = paeth_pick(a, b, c);
      default:    pred = 8'h00;
    endcase
    val               = enc + pred;
    left_hist[slot]   = val;
    upleft_hist[slot] = b;
    line_mem[col]     = val;
    row_end = (col + 1 >= rb);
    img_end = row_end && (row_pos + 1 >= eff_image_rows());
    res      = '{pixel: val, row_end: row_end, image_end: img_end, bad: row_bad};
    produced = 1'b1;
    if (row_end) begin
      col_pos   = 0;
      want_code = 1'b1;
      row_pos   = img_end ? 0 : ((row_pos + 1) & 32'hFFFF);
    end else begin
      col_pos = (col + 1) & 32'h1FFF;
    end
  endfunction

  function automatic logic [7:0] pick_code();
    if ($urandom_range(0, 6) == 0)
      return 8'($urandom_range(int'(BAD_CODE_MIN), int'(BAD_CODE_MAX)));
    return 8'($urandom_range(int'(FILT_NONE), int'(FILT_PAETH)));
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_REPORTS) $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Send one byte transfer, with an occasional random gap in front of it
  task automatic send_byte(input logic [7:0] value);
    bit            produced;
    pixel_result_t res;
    if (gaps_on) begin
      if (no_gap_left > 0) begin
        no_gap_left--;
      end else if ($urandom_range(0, 49) == 0) begin
        no_gap_left = $urandom_range(30, 150);
      end else if ($urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
    end
    in_valid     <= 1'b1;
    encoded_byte <= value;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    items_sent++;
    unfilter_byte(value, produced, res);
    if (produced) expected_pixels.push_back(res);
  endtask

  // Stop sending and let the block finish everything in flight
  task automatic go_idle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(value);
    @(posedge clk);
    case (idx)
      CFG_ROW_BYTES:   cfg_row_bytes   = value & 32'h1FFF;
      CFG_PIXEL_BYTES: cfg_pixel_bytes = value & 32'hF;
      CFG_IMAGE_ROWS:  cfg_image_rows  = value & 32'hFFFF;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input int unsigned rb, input int unsigned pxb,
                            input int unsigned rows);
    write_reg(CFG_ROW_BYTES, rb);
    write_reg(CFG_PIXEL_BYTES, pxb);
    write_reg(CFG_IMAGE_ROWS, rows);
  endtask

  // Whole image: filter code plus row data, for every row
  task automatic send_image();
    int unsigned rb, rows;
    rb   = eff_row_bytes();
    rows = eff_image_rows();
    repeat (rows) begin
      send_byte(pick_code());
      repeat (rb) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // Every filter, first-row up, left edge, data extremes, bad code
  task automatic check_filter_basics();
    set_config(3, 2, 6);
    foreach (DIRECTED_BYTES[i]) send_byte(DIRECTED_BYTES[i]);
    go_idle();
  endtask

  // Zero and oversized registers
  task automatic check_register_extremes();
    set_config(0, 0, 0);
    send_byte(BAD_CODE_MIN);
    send_byte(8'h3C);
    send_byte(8'(FILT_PAETH));
    send_byte(8'hC3);
    go_idle();
    // oversized row and pixel sizes: the row stays open well past 40 bytes
    set_config(13'h1FFF, 4'hF, 1);
    send_byte(8'(FILT_SUB));
    repeat (40) send_byte(8'($urandom_range(0, 255)));
    go_idle();
    // shorten the row so the next byte closes the image
    write_reg(CFG_ROW_BYTES, 41);
    send_byte(8'($urandom_range(0, 255)));
    go_idle();
  endtask

  // Registers rewritten with an image half done take effect at once
  task automatic check_midimage_changes();
    set_config(10, 3, 4);
    send_byte(8'(FILT_SUB));
    repeat (10) send_byte(8'($urandom_range(0, 255)));
    send_byte(8'(FILT_PAETH));
    repeat (5) send_byte(8'($urandom_range(0, 255)));
    go_idle();
    // column now past the shorter row: this byte closes it
    write_reg(CFG_ROW_BYTES, 4);
    send_byte(8'($urandom_range(0, 255)));
    send_byte(8'(FILT_AVG));
    send_byte(8'($urandom_range(0, 255)));
    go_idle();
    write_reg(CFG_PIXEL_BYTES, 1);
    send_byte(8'($urandom_range(0, 255)));
    go_idle();
    // row count already reached: this row ends the image
    write_reg(CFG_IMAGE_ROWS, 2);
    repeat (2) send_byte(8'($urandom_range(0, 255)));
    go_idle();
    set_config(1, 1, 16'hFFFF);
    repeat (3) begin
      send_byte(pick_code());
      send_byte(8'($urandom_range(0, 255)));
    end
    go_idle();
    write_reg(CFG_IMAGE_ROWS, 2);
    send_byte(8'(FILT_UP));
    send_byte(8'($urandom_range(0, 255)));
    go_idle();
  endtask

  // Random settings, one or two whole images each
  task automatic check_random_images();
    int          start;
    int unsigned rb, pxb;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) rb = 0;
      else if ($urandom_range(0, 9) == 0) rb = $urandom_range(65, 130);
      else rb = $urandom_range(1, 40);
      pxb = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
      set_config(rb, pxb, $urandom_range(0, 6));
      repeat ($urandom_range(1, 2)) send_image();
      go_idle();
    end
  endtask

  // Back-to-back transfers with no gaps and no stalls
  task automatic check_streaming();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    go_idle();
    set_config(16, 4, 3);
    repeat (STREAM_IMAGES) send_image();
    in_valid <= 1'b0;
  endtask

  // Output stall bursts, with occasional long stall-free stretches
  initial begin
    forever begin
      @(posedge clk);
      if (stalls_on && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 59) == 0) begin
        repeat ($urandom_range(40, 200)) @(posedge clk);
      end
    end
  end

  // Compare each output transfer with the oldest prediction
  always @(posedge clk) begin
    pixel_result_t want;
    if (rst_n && out_valid_o && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected output byte %02h", pixel_byte_o));
      end else begin
        want = expected_pixels.pop_front();
        if (pixel_byte_o !== want.pixel)
          report_mismatch($sformatf("pixel_byte %02h, want %02h", pixel_byte_o, want.pixel));
        if (last_in_row_o !== want.row_end)
          report_mismatch($sformatf("last_in_row %b, want %b", last_in_row_o, want.row_end));
        if (last_in_image_o !== want.image_end)
          report_mismatch($sformatf("last_in_image %b, want %b", last_in_image_o,
                                    want.image_end));
        if (bad_filter_o !== want.bad)
          report_mismatch($sformatf("bad_filter %b, want %b", bad_filter_o, want.bad));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("png_scanline_unfilter_core regression: fail");
      $finish;
    end
  end

  initial begin
    int waited;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_filter_basics();
    check_register_extremes();
    check_midimage_changes();
    check_random_images();
    check_streaming();
    waited = 0;
    while (expected_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_pixels.size() != 0)
      report_mismatch($sformatf("%0d output bytes never arrived", expected_pixels.size()));
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("png_scanline_unfilter_core regression: pass");
    end else begin
      $display("png_scanline_unfilter_core regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/png_unf_pkg.sv
sv/png_unf_line_buf.sv
sv/png_unf_predictor.sv
sv/png_scanline_unfilter_core.sv
dv/tb_png_scanline_unfilter_core.sv
